FILE: rtl/pls_pkg.sv
package pls_pkg;

  // Number of cells in the row.
  localparam int DEPTH = 16;

  // Field widths of the request and result.
  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int STAT_W = 2;
  localparam int OUT_CNT_W = 5;

  // Internal widths that follow from the depth.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_INS_FIRST = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_LAST = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_AT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_LAST = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_AT = 3'd5;
  localparam logic [ACT_W-1:0] ACT_DUMP = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  // Cell source select codes.
  localparam int SEL_W = 3;
  localparam logic [SEL_W-1:0] SEL_HOLD = 3'd0;
  localparam logic [SEL_W-1:0] SEL_LOAD = 3'd1;
  localparam logic [SEL_W-1:0] SEL_LEFT = 3'd2;
  localparam logic [SEL_W-1:0] SEL_RIGHT = 3'd3;
  localparam logic [SEL_W-1:0] SEL_HEAD = 3'd4;

  typedef logic [SEL_W-1:0] sel_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic signed [VAL_W-1:0] out_value;
    logic [OUT_CNT_W-1:0] entry_count;
    logic last;
  } rsp_t;

endpackage

FILE: rtl/positional_list_store_core.sv
// Ordered store of up to DEPTH signed 32-bit values, kept in a row of cells.
// Requests enter on in_valid/in_stall/in_req; results leave on
// out_valid/out_stall/out_rsp. A request is taken when valid is high and
// stall is low at a rising clock edge.
// Insert and delete requests each give one result, registered at the edge that
// takes the request. Every cell at or past the edit place shifts toward or
// away from its neighbor at that same edge, so one edit request can be taken
// every cycle while the receiver keeps up.
// A dump of N values gives no result for its own request, then one result per
// cycle while the receiver keeps up, head first, with last set on the final one.
// The row rotates by one place per result within the stored values, so after
// the dump the list is back in its original order. in_stall stays high for it.
// An empty dump gives a single result with status empty.
// When the receiver stalls, the result register holds and in_stall rises, so no
// further request is taken until the result is gone.
// A synchronous reset empties the list and drops any pending result; stored
// values themselves are not cleared, since only filled places are ever read.
module positional_list_store_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pls_pkg::req_t  in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output pls_pkg::rsp_t  out_rsp
);

  logic [pls_pkg::CNT_W-1:0] count;
  logic [pls_pkg::CNT_W-1:0] count_next;
  logic                      dumping;
  logic [pls_pkg::CNT_W-1:0] dump_left;

  pls_pkg::val_t cell_data [pls_pkg::DEPTH];
  pls_pkg::sel_t cell_sel  [pls_pkg::DEPTH];

  logic out_free;
  logic in_acc;
  logic dump_step;
  logic do_ins;
  logic do_del;
  logic start_dump;
  logic [pls_pkg::CNT_W-1:0] edit_idx;
  logic [pls_pkg::CNT_W-1:0] cnt_m1;
  logic [pls_pkg::CMP_W-1:0] pos_ext;
  logic [pls_pkg::CMP_W-1:0] cnt_ext;
  logic is_full;
  logic is_empty;
  pls_pkg::rsp_t edit_rsp;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = dumping || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign dump_step = dumping && out_free;
  assign cnt_m1    = count - pls_pkg::CNT_W'(1);
  assign pos_ext   = pls_pkg::CMP_W'(in_req.position);
  assign cnt_ext   = pls_pkg::CMP_W'(count);
  assign is_full   = (count == pls_pkg::CNT_W'(pls_pkg::DEPTH));
  assign is_empty  = (count == '0);

  // Decode the request: status, edit place and the new count.
  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    start_dump = 1'b0;
    edit_idx   = '0;
    count_next = count;
    edit_rsp.status = pls_pkg::ST_OK;
    case (in_req.action)
      pls_pkg::ACT_INS_FIRST, pls_pkg::ACT_INS_LAST, pls_pkg::ACT_INS_AT: begin
        if (is_full) begin
          edit_rsp.status = pls_pkg::ST_FULL;
        end else if (in_req.action == pls_pkg::ACT_INS_FIRST) begin
          do_ins = 1'b1;
        end else if (in_req.action == pls_pkg::ACT_INS_LAST) begin
          do_ins   = 1'b1;
          edit_idx = count;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + pls_pkg::CMP_W'(1)) begin
          edit_rsp.status = pls_pkg::ST_BADPOS;
        end else begin
          do_ins   = 1'b1;
          edit_idx = pls_pkg::CNT_W'(pos_ext - pls_pkg::CMP_W'(1));
        end
        if (do_ins) begin
          count_next = count + pls_pkg::CNT_W'(1);
        end
      end
      pls_pkg::ACT_DEL_FIRST, pls_pkg::ACT_DEL_LAST, pls_pkg::ACT_DEL_AT: begin
        if (is_empty) begin
          edit_rsp.status = pls_pkg::ST_EMPTY;
        end else if (in_req.action == pls_pkg::ACT_DEL_FIRST) begin
          do_del = 1'b1;
        end else if (in_req.action == pls_pkg::ACT_DEL_LAST) begin
          do_del   = 1'b1;
          edit_idx = cnt_m1;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          edit_rsp.status = pls_pkg::ST_BADPOS;
        end else begin
          do_del   = 1'b1;
          edit_idx = pls_pkg::CNT_W'(pos_ext - pls_pkg::CMP_W'(1));
        end
        if (do_del) begin
          count_next = cnt_m1;
        end
      end
      pls_pkg::ACT_DUMP: begin
        if (is_empty) begin
          edit_rsp.status = pls_pkg::ST_EMPTY;
        end else begin
          start_dump = 1'b1;
        end
      end
      default: begin
      end
    endcase
    edit_rsp.out_value   = do_del ? cell_data[edit_idx[pls_pkg::IDX_W-1:0]] : '0;
    edit_rsp.entry_count = pls_pkg::OUT_CNT_W'(count_next);
    edit_rsp.last        = 1'b1;
  end

  // Per-cell source select: shift right on insert, left on delete, rotate on dump.
  always_comb begin
    for (int i = 0; i < pls_pkg::DEPTH; i++) begin
      cell_sel[i] = pls_pkg::SEL_HOLD;
      if (dump_step) begin
        if (pls_pkg::CNT_W'(i) == cnt_m1) begin
          cell_sel[i] = pls_pkg::SEL_HEAD;
        end else if (pls_pkg::CNT_W'(i) < cnt_m1) begin
          cell_sel[i] = pls_pkg::SEL_RIGHT;
        end
      end else if (in_acc && do_ins) begin
        if (pls_pkg::CNT_W'(i) > edit_idx) begin
          cell_sel[i] = pls_pkg::SEL_LEFT;
        end else if (pls_pkg::CNT_W'(i) == edit_idx) begin
          cell_sel[i] = pls_pkg::SEL_LOAD;
        end
      end else if (in_acc && do_del) begin
        if (pls_pkg::CNT_W'(i) >= edit_idx) begin
          cell_sel[i] = pls_pkg::SEL_RIGHT;
        end
      end
    end
  end

  // The row of cells, each linked to both neighbors and to the head.
  for (genvar g = 0; g < pls_pkg::DEPTH; g++) begin : g_cell
    pls_pkg::val_t left_val;
    pls_pkg::val_t right_val;
    if (g == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_data[g-1];
    end
    if (g == pls_pkg::DEPTH - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_data[g+1];
    end
    pls_cell u_cell (
      .clk   (clk),
      .sel   (cell_sel[g]),
      .load  (in_req.item_value),
      .left  (left_val),
      .right (right_val),
      .head  (cell_data[0]),
      .data  (cell_data[g])
    );
  end

  // Count and dump sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dumping   <= 1'b0;
      dump_left <= '0;
    end else if (dump_step) begin
      dump_left <= dump_left - pls_pkg::CNT_W'(1);
      if (dump_left == pls_pkg::CNT_W'(1)) begin
        dumping <= 1'b0;
      end
    end else if (in_acc) begin
      count <= count_next;
      if (start_dump) begin
        dumping   <= 1'b1;
        dump_left <= count;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && !start_dump) begin
      out_valid <= 1'b1;
    end else if (dump_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !start_dump) begin
      out_rsp <= edit_rsp;
    end else if (dump_step) begin
      out_rsp.status      <= pls_pkg::ST_OK;
      out_rsp.out_value   <= cell_data[0];
      out_rsp.entry_count <= pls_pkg::OUT_CNT_W'(count);
      out_rsp.last        <= (dump_left == pls_pkg::CNT_W'(1));
    end
  end

  // The count never runs past the number of cells.
  assert property (@(posedge clk) disable iff (rst)
    count <= pls_pkg::CNT_W'(pls_pkg::DEPTH))
    else $error("list count exceeds depth");

  // A dump leaves the count untouched.
  assert property (@(posedge clk) disable iff (rst)
    dumping |=> count == $past(count))
    else $error("count changed during dump");

  // Only a dump produces results that are not the last of their request.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.last |-> dumping)
    else $error("non-final result outside a dump");

  // A running dump always has results left to send.
  assert property (@(posedge clk) disable iff (rst)
    dumping |-> dump_left != '0)
    else $error("dump running with nothing left");

endmodule

FILE: rtl/pls_cell.sv
module pls_cell (
  input  logic            clk,
  input  pls_pkg::sel_t   sel,
  input  pls_pkg::val_t   load,
  input  pls_pkg::val_t   left,
  input  pls_pkg::val_t   right,
  input  pls_pkg::val_t   head,
  output pls_pkg::val_t   data
);

  pls_pkg::val_t data_next;

  // Pick the source for this cell's stored value.
  always_comb begin
    case (sel)
      pls_pkg::SEL_LOAD:  data_next = load;
      pls_pkg::SEL_LEFT:  data_next = left;
      pls_pkg::SEL_RIGHT: data_next = right;
      pls_pkg::SEL_HEAD:  data_next = head;
      default:            data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: tb/sv/list_check_pkg.sv
`timescale 1ns / 100ps

package list_check_pkg;

  import pls_pkg::*;

  // Shadow copy of the ordered list plus the queue of results still owed by
  // the block. Requests are applied in the order the block accepts them.
  class list_scoreboard;

    val_t held_values[DEPTH];
    int held_count = 0;
    rsp_t owed_results[$];
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;

    // Open a gap at index at and place v there.
    function void shift_in(int at, val_t v);
      for (int i = held_count; i > at; i--) begin
        held_values[i] = held_values[i-1];
      end
      held_values[at] = v;
      held_count++;
    endfunction

    // Remove the value at index at and close the gap behind it.
    function val_t shift_out(int at);
      val_t v;
      v = held_values[at];
      for (int i = at; i + 1 < held_count; i++) begin
        held_values[i] = held_values[i+1];
      end
      held_count--;
      return v;
    endfunction

    function void queue_result(logic [STAT_W-1:0] status, val_t value, logic fin);
      rsp_t r;
      r.status = status;
      r.out_value = value;
      r.entry_count = OUT_CNT_W'(held_count);
      r.last = fin;
      owed_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow list and queue what it owes.
    function void apply_request(req_t req);
      logic [STAT_W-1:0] status;
      val_t removed;
      int pos;
      status = ST_OK;
      removed = '0;
      pos = int'(req.position);
      case (req.action)
        ACT_INS_FIRST, ACT_INS_LAST, ACT_INS_AT: begin
          // A full list is reported before the position is looked at.
          if (held_count >= DEPTH) begin
            status = ST_FULL;
          end else if (req.action == ACT_INS_FIRST) begin
            shift_in(0, req.item_value);
          end else if (req.action == ACT_INS_LAST) begin
            shift_in(held_count, req.item_value);
          end else if (pos < 1 || pos > held_count + 1) begin
            status = ST_BADPOS;
          end else begin
            shift_in(pos - 1, req.item_value);
          end
        end
        ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_AT: begin
          // An empty list is reported before the position is looked at.
          if (held_count == 0) begin
            status = ST_EMPTY;
          end else if (req.action == ACT_DEL_FIRST) begin
            removed = shift_out(0);
          end else if (req.action == ACT_DEL_LAST) begin
            removed = shift_out(held_count - 1);
          end else if (pos < 1 || pos > held_count) begin
            status = ST_BADPOS;
          end else begin
            removed = shift_out(pos - 1);
          end
        end
        ACT_DUMP: begin
          // A non-empty dump owes one result per value, head first.
          if (held_count == 0) begin
            status = ST_EMPTY;
          end else begin
            for (int i = 0; i < held_count; i++) begin
              queue_result(ST_OK, held_values[i], i + 1 == held_count);
            end
            return;
          end
        end
        default: begin
        end
      endcase
      queue_result(status, removed, 1'b1);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 40) begin
        $display("mismatch at %0t: %s", $time, what);
      end
      mismatches++;
    endtask

    // Compare one accepted result with the oldest one owed.
    task check_result(rsp_t got);
      rsp_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none owed", results_seen));
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  results_seen, got.status, want.status));
      end
      if (got.out_value !== want.out_value) begin
        report_mismatch($sformatf("result %0d out_value %0d, want %0d",
                                  results_seen, got.out_value, want.out_value));
      end
      if (got.entry_count !== want.entry_count) begin
        report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                  results_seen, got.entry_count, want.entry_count));
      end
      if (got.last !== want.last) begin
        report_mismatch($sformatf("result %0d last %0b, want %0b",
                                  results_seen, got.last, want.last));
      end
    endtask

  endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  import pls_pkg::*;
  import list_check_pkg::*;

  // Action code the block does not define; it must change nothing.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 196;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  logic calm = 1'b0;
  int requests_sent = 0;
  list_scoreboard sb;

  positional_list_store_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp(out_rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: check accepted results and stall at random.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_rsp);
    end
    out_stall <= !rst && !calm && ($urandom_range(99) < 22);
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(req_t req);
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_request(req);
    requests_sent++;
  endtask

  task automatic send_fields(logic [ACT_W-1:0] action, val_t value,
                             logic [POS_W-1:0] position);
    req_t req;
    req.action = action;
    req.item_value = value;
    req.position = position;
    send_request(req);
  endtask

  // Random gap between requests unless in a calm stretch.
  task automatic sender_idle();
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.owed_results.size() != 0);
  endtask

  function automatic logic [ACT_W-1:0] pick_insert();
    case ($urandom_range(2))
      0: return ACT_INS_FIRST;
      1: return ACT_INS_LAST;
      default: return ACT_INS_AT;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_delete();
    case ($urandom_range(2))
      0: return ACT_DEL_FIRST;
      1: return ACT_DEL_LAST;
      default: return ACT_DEL_AT;
    endcase
  endfunction

  // Random request biased by the mix; most positions land near the valid range.
  function automatic req_t pick_request(mix_t mix);
    req_t req;
    int roll;
    case ($urandom_range(9))
      0: req.item_value = 32'sh8000_0000;
      1: req.item_value = 32'sh7fff_ffff;
      2: req.item_value = '0;
      3: req.item_value = '1;
      default: req.item_value = $urandom;
    endcase
    if ($urandom_range(99) < 85) begin
      req.position = POS_W'($urandom_range(sb.held_count + 2, 0));
    end else begin
      req.position = POS_W'($urandom);
    end
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:
        req.action = (roll < 80) ? pick_insert() : (roll < 90) ? ACT_DUMP : ACT_W'($urandom);
      MIX_DRAIN:
        req.action = (roll < 75) ? pick_delete() : (roll < 85) ? ACT_DUMP : ACT_W'($urandom);
      default: begin
        if (roll < 45) begin
          req.action = pick_insert();
        end else if (roll < 85) begin
          req.action = pick_delete();
        end else if (roll < 95) begin
          req.action = ACT_DUMP;
        end else begin
          req.action = ACT_UNUSED;
        end
      end
    endcase
    return req;
  endfunction

  // Fill and drain mixes run until the list is full or empty, plus a few more.
  task automatic run_mix(mix_t mix);
    int n;
    int tail;
    n = 0;
    tail = 0;
    while (n < 60 && tail < 3 && requests_sent < 24 + RANDOM_REQUESTS) begin
      send_request(pick_request(mix));
      n++;
      if (mix == MIX_BALANCED) begin
        if (n >= 28) tail++;
      end else if (sb.held_count == ((mix == MIX_FILL) ? DEPTH : 0)) begin
        tail++;
      end
      sender_idle();
    end
  endtask

  initial begin
    int step;
    mix_t order[4];
    sb = new;
    order[0] = MIX_FILL;
    order[1] = MIX_BALANCED;
    order[2] = MIX_DRAIN;
    order[3] = MIX_BALANCED;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests: empty list, bad positions, one-entry deletes,
    // the unused action, value extremes and small dumps.
    send_fields(ACT_DUMP, '0, 5'd0);
    send_fields(ACT_DEL_FIRST, '0, 5'd0);
    send_fields(ACT_DEL_LAST, '0, 5'd0);
    send_fields(ACT_DEL_AT, '0, 5'd1);
    send_fields(ACT_INS_AT, 32'sd5, 5'd0);
    send_fields(ACT_INS_AT, 32'sd6, 5'd2);
    send_fields(ACT_INS_AT, 32'sh8000_0000, 5'd1);
    sender_idle();
    send_fields(ACT_DEL_AT, '0, 5'd0);
    send_fields(ACT_DEL_AT, '0, 5'd2);
    send_fields(ACT_DUMP, '0, 5'd0);
    send_fields(ACT_DEL_AT, '0, 5'd1);
    send_fields(ACT_UNUSED, 32'sh1234_5678, 5'd31);
    send_fields(ACT_INS_FIRST, 32'sh7fff_ffff, 5'd0);
    sender_idle();
    send_fields(ACT_INS_LAST, '1, 5'd0);
    send_fields(ACT_INS_AT, '0, 5'd2);
    send_fields(ACT_INS_AT, 32'sh5555_5555, 5'd4);
    send_fields(ACT_DUMP, '0, 5'd0);
    send_fields(ACT_DEL_AT, '0, 5'd31);
    send_fields(ACT_DEL_AT, '0, 5'd2);
    sender_idle();
    send_fields(ACT_DEL_FIRST, '0, 5'd0);
    send_fields(ACT_DEL_LAST, '0, 5'd0);
    send_fields(ACT_DEL_LAST, '0, 5'd0);
    send_fields(ACT_INS_FIRST, 32'shaaaa_aaaa, 5'd16);
    send_fields(ACT_DEL_FIRST, '0, 5'd0);

    // Random part: fill to full, calm balanced, drain, balanced, and so on.
    step = 0;
    while (requests_sent < 24 + RANDOM_REQUESTS) begin
      calm <= (step == 1);
      run_mix(order[step % 4]);
      if (step == 0) wait_drained();
      step++;
    end
    calm <= 1'b0;

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #3_200_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: positional_list_store_core.f
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/positional_list_store_core.sv
tb/sv/list_check_pkg.sv
tb/sv/tb.sv
